@@ hw/rtl/framebuffer_slot_cache_assert.svh @@
// Assertion macros used by the framebuffer slot cache checker.
`ifndef FRAMEBUFFER_SLOT_CACHE_ASSERT_SVH
`define FRAMEBUFFER_SLOT_CACHE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framebuffer slot cache assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framebuffer slot cache assertion failed");

`endif

@@ hw/rtl/fsc_pkg.sv @@
// Shared types and constants of the framebuffer slot cache.
package fsc_pkg;

  localparam int SLOTS       = 8;
  localparam int STAMP_BITS  = 32;
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 11;
  localparam int ADDR_BITS   = 24;

  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 8;
  localparam int OUT_USER_BITS = 3;

  localparam int IN_WIDTH_LSB  = 0;
  localparam int IN_HEIGHT_LSB = IN_WIDTH_LSB + WIDTH_BITS;
  localparam int IN_ADDR_LSB   = IN_HEIGHT_LSB + HEIGHT_BITS;

  localparam int OUT_USER_HIT  = 0;
  localparam int OUT_USER_FILL = 1;
  localparam int OUT_USER_FLIP = 2;

  typedef enum logic {
    ACT_DISPLAY = 1'b0,
    ACT_RENDER  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ hw/rtl/framebuffer_slot_cache.sv @@
// Top level of the framebuffer slot cache: controller and datapath.
// Each request is accepted in the idle state, then one slot is scanned per cycle.
// After the last slot is scanned, the commit state waits until the output register is free,
// then registers the result, and the block returns to the idle state for the next request.
// A pending result does not block acceptance of the next request.
// Reset is synchronous and active low and clears all valid and flip marks.
module framebuffer_slot_cache
  import fsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // Fields from bit 0: frame_width, frame_height, start_address, zero fill.
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // Fields from bit 0: action.
  input  logic                     in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // Fields from bit 0: slot_index, zero fill.
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // Fields from bit 0: hit, needs_fill, flip_mark.
  output logic [OUT_USER_BITS-1:0] out_tuser
);

  dp_cmd_t    cmd;
  dp_status_t status;

  fsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  fsc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ hw/rtl/fsc_ctrl.sv @@
// Controller state machine that sequences accept, slot scan and commit.
module fsc_ctrl
  import fsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/fsc_dp.sv @@
// Datapath with the slot table, the serial slot scan and the result register.
module fsc_dp
  import fsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  input  logic                     in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic [OUT_USER_BITS-1:0] out_tuser
);

  logic [WIDTH_BITS-1:0]  tag_width_r   [SLOTS];
  logic [HEIGHT_BITS-1:0] tag_height_r  [SLOTS];
  logic [ADDR_BITS-1:0]   tag_address_r [SLOTS];
  logic [STAMP_BITS-1:0]  slot_stamp_r  [SLOTS];
  logic [SLOTS-1:0]       slot_valid_r;
  logic [SLOTS-1:0]       slot_flip_r;
  logic [STAMP_BITS-1:0]  stamp_ctr_r;

  action_t                req_action_r;
  logic [WIDTH_BITS-1:0]  req_width_r;
  logic [HEIGHT_BITS-1:0] req_height_r;
  logic [ADDR_BITS-1:0]   req_address_r;

  logic [SLOT_BITS-1:0]   scan_idx_r;
  logic                   match_found_r;
  logic [SLOT_BITS-1:0]   match_idx_r;
  logic                   match_flip_r;
  logic                   inv_found_r;
  logic [SLOT_BITS-1:0]   inv_idx_r;
  logic [STAMP_BITS-1:0]  best_stamp_r;
  logic [SLOT_BITS-1:0]   victim_idx_r;

  logic                   out_valid_r;
  logic [SLOT_BITS-1:0]   out_slot_r;
  logic                   out_hit_r;
  logic                   out_fill_r;
  logic                   out_flip_r;

  logic                   key_match;
  logic                   stamp_better;
  logic [SLOT_BITS-1:0]   chosen_slot;
  logic                   do_write;
  logic                   flip_new;
  logic                   flip_result;

  assign key_match = slot_valid_r[scan_idx_r]
                     && (tag_width_r[scan_idx_r] == req_width_r)
                     && (tag_height_r[scan_idx_r] == req_height_r)
                     && (tag_address_r[scan_idx_r] == req_address_r);

  // Ties go to the later slot, so an equal stamp replaces the current best.
  assign stamp_better = (scan_idx_r == '0) || (slot_stamp_r[scan_idx_r] <= best_stamp_r);

  always_comb begin
    priority if (match_found_r) begin
      chosen_slot = match_idx_r;
    end else if (inv_found_r) begin
      chosen_slot = inv_idx_r;
    end else begin
      chosen_slot = victim_idx_r;
    end
  end

  assign flip_new    = (req_action_r == ACT_DISPLAY);
  assign do_write    = cmd.commit && ((req_action_r == ACT_RENDER) || !match_found_r);
  assign flip_result = (match_found_r && (req_action_r == ACT_DISPLAY)) ? match_flip_r
                                                                        : flip_new;

  assign status.scan_last = (scan_idx_r == SLOT_BITS'(SLOTS - 1));
  assign status.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      slot_flip_r  <= '0;
      stamp_ctr_r  <= '0;
      scan_idx_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx_r <= '0;
      end else if (cmd.scan) begin
        scan_idx_r <= SLOT_BITS'(scan_idx_r + 1'b1);
      end
      if (do_write) begin
        slot_valid_r[chosen_slot] <= 1'b1;
        slot_flip_r[chosen_slot]  <= flip_new;
        stamp_ctr_r               <= STAMP_BITS'(stamp_ctr_r + 1'b1);
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action_r  <= action_t'(in_tuser);
      req_width_r   <= in_tdata[IN_WIDTH_LSB +: WIDTH_BITS];
      req_height_r  <= in_tdata[IN_HEIGHT_LSB +: HEIGHT_BITS];
      req_address_r <= in_tdata[IN_ADDR_LSB +: ADDR_BITS];
      match_found_r <= 1'b0;
      inv_found_r   <= 1'b0;
    end else if (cmd.scan) begin
      if (!match_found_r && key_match) begin
        match_found_r <= 1'b1;
        match_idx_r   <= scan_idx_r;
        match_flip_r  <= slot_flip_r[scan_idx_r];
      end
      if (!inv_found_r && !slot_valid_r[scan_idx_r]) begin
        inv_found_r <= 1'b1;
        inv_idx_r   <= scan_idx_r;
      end
      if (stamp_better) begin
        best_stamp_r <= slot_stamp_r[scan_idx_r];
        victim_idx_r <= scan_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      tag_width_r[chosen_slot]   <= req_width_r;
      tag_height_r[chosen_slot]  <= req_height_r;
      tag_address_r[chosen_slot] <= req_address_r;
      slot_stamp_r[chosen_slot]  <= stamp_ctr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_slot_r <= chosen_slot;
      out_hit_r  <= match_found_r;
      out_fill_r <= (req_action_r == ACT_DISPLAY) && !match_found_r;
      out_flip_r <= flip_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_BITS - SLOT_BITS){1'b0}}, out_slot_r};
  assign out_tuser  = {out_flip_r, out_fill_r, out_hit_r};

endmodule

@@ hw/rtl/fsc_checker.sv @@
// Port-level checker for the framebuffer slot cache and its bind statement.
`include "framebuffer_slot_cache_assert.svh"

module fsc_checker
  import fsc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata,
  input logic [OUT_USER_BITS-1:0] out_tuser
);

  `FSC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `FSC_ASSERT_NOW(a_fill_not_hit, out_tvalid,
                  !(out_tuser[OUT_USER_HIT] && out_tuser[OUT_USER_FILL]))
  `FSC_ASSERT_NOW(a_fill_sets_flip, out_tvalid && out_tuser[OUT_USER_FILL],
                  out_tuser[OUT_USER_FLIP])
  `FSC_ASSERT_NEXT(a_one_request, in_tvalid && in_tready, !in_tready)

endmodule

bind framebuffer_slot_cache fsc_checker u_fsc_checker (.*);

@@ test/framebuffer_slot_cache_tb.sv @@
// Self-checking testbench for the framebuffer slot cache with a predicting scoreboard.
`timescale 1ns / 100ps

module framebuffer_slot_cache_tb;
  import fsc_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [SLOT_BITS-1:0] slot_index;
    logic                 hit;
    logic                 needs_fill;
    logic                 flip_mark;
  } slot_result_t;

  class slot_cache_scoreboard;
    logic [WIDTH_BITS-1:0]  tag_width [SLOTS];
    logic [HEIGHT_BITS-1:0] tag_height [SLOTS];
    logic [ADDR_BITS-1:0]   tag_address [SLOTS];
    logic                   slot_valid [SLOTS];
    logic                   slot_flip [SLOTS];
    logic [STAMP_BITS-1:0]  slot_stamp [SLOTS];
    logic [STAMP_BITS-1:0]  stamp_counter;
    slot_result_t           awaited_results[$];
    int                     error_count;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        tag_width[i] = '0;
        tag_height[i] = '0;
        tag_address[i] = '0;
        slot_valid[i] = 1'b0;
        slot_flip[i] = 1'b0;
        slot_stamp[i] = '0;
      end
      stamp_counter = '0;
      error_count = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
    endtask

    function int lowest_victim();
      int victim;
      logic [STAMP_BITS-1:0] best;
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_valid[i]) return i;
      end
      victim = 0;
      best = slot_stamp[0];
      for (int i = 1; i < SLOTS; i++) begin
        if (slot_stamp[i] <= best) begin
          best = slot_stamp[i];
          victim = i;
        end
      end
      return victim;
    endfunction

    function void store_key(int s, logic [WIDTH_BITS-1:0] w, logic [HEIGHT_BITS-1:0] h,
                            logic [ADDR_BITS-1:0] a, logic flip);
      slot_valid[s] = 1'b1;
      slot_flip[s] = flip;
      tag_width[s] = w;
      tag_height[s] = h;
      tag_address[s] = a;
      slot_stamp[s] = stamp_counter;
      stamp_counter = stamp_counter + 1'b1;
    endfunction

    function void note_request(action_t act, logic [WIDTH_BITS-1:0] w,
                               logic [HEIGHT_BITS-1:0] h, logic [ADDR_BITS-1:0] a);
      int s;
      slot_result_t res;
      s = -1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (slot_valid[i] && tag_width[i] == w && tag_height[i] == h &&
            tag_address[i] == a)
          s = i;
      end
      res.hit = (s >= 0);
      res.needs_fill = 1'b0;
      if (act == ACT_DISPLAY) begin
        if (s < 0) begin
          s = lowest_victim();
          store_key(s, w, h, a, 1'b1);
          res.needs_fill = 1'b1;
        end
      end else begin
        if (s < 0) s = lowest_victim();
        store_key(s, w, h, a, 1'b0);
      end
      res.slot_index = s[SLOT_BITS-1:0];
      res.flip_mark = slot_flip[s];
      awaited_results.push_back(res);
    endfunction

    task check_result(logic [OUT_DATA_BITS-1:0] data, logic [OUT_USER_BITS-1:0] user);
      slot_result_t res;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h tuser=%b", data, user));
        return;
      end
      res = awaited_results.pop_front();
      if (data[SLOT_BITS-1:0] !== res.slot_index)
        report_mismatch($sformatf("slot_index %0d, predicted %0d",
                                  data[SLOT_BITS-1:0], res.slot_index));
      if (data[OUT_DATA_BITS-1:SLOT_BITS] !== '0)
        report_mismatch($sformatf("tdata fill bits not zero: %h", data));
      if (user[OUT_USER_HIT] !== res.hit)
        report_mismatch($sformatf("hit %b, predicted %b", user[OUT_USER_HIT], res.hit));
      if (user[OUT_USER_FILL] !== res.needs_fill)
        report_mismatch($sformatf("needs_fill %b, predicted %b",
                                  user[OUT_USER_FILL], res.needs_fill));
      if (user[OUT_USER_FLIP] !== res.flip_mark)
        report_mismatch($sformatf("flip_mark %b, predicted %b",
                                  user[OUT_USER_FLIP], res.flip_mark));
    endtask
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic                     in_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [OUT_USER_BITS-1:0] out_tuser;

  slot_cache_scoreboard sb = new();
  int in_idle_max = 0;
  int out_idle_max = 0;
  int idle_cycles = 0;

  logic [WIDTH_BITS-1:0]  pool_w [12];
  logic [HEIGHT_BITS-1:0] pool_h [12];
  logic [ADDR_BITS-1:0]   pool_a [12];

  framebuffer_slot_cache dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The receiver stalls a random number of cycles before each transaction.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, out_idle_max);
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata, out_tuser);
    end
  end

  task send_request(action_t act, logic [WIDTH_BITS-1:0] w, logic [HEIGHT_BITS-1:0] h,
                    logic [ADDR_BITS-1:0] a);
    int gap;
    gap = $urandom_range(0, in_idle_max);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = act;
    in_tdata = '0;
    in_tdata[IN_WIDTH_LSB +: WIDTH_BITS] = w;
    in_tdata[IN_HEIGHT_LSB +: HEIGHT_BITS] = h;
    in_tdata[IN_ADDR_LSB +: ADDR_BITS] = a;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(act, w, h, a);
    @(negedge clk);
  endtask

  task hold_until_drained();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function logic [WIDTH_BITS-1:0] random_dim();
    if ($urandom_range(0, 4) == 0) return WIDTH_BITS'($urandom_range(0, 2047));
    return WIDTH_BITS'($urandom_range(1, 1024));
  endfunction

  function void build_key_pool();
    for (int i = 0; i < 12; i++) begin
      pool_w[i] = random_dim();
      pool_h[i] = random_dim();
      pool_a[i] = ADDR_BITS'($urandom);
    end
    // Keys that share two of three parts make near misses common.
    pool_w[1] = pool_w[0];
    pool_h[1] = pool_h[0];
    pool_a[2] = pool_a[0];
    pool_w[2] = pool_w[0];
  endfunction

  task random_request();
    int pick;
    int r;
    action_t act;
    logic [WIDTH_BITS-1:0] w;
    logic [HEIGHT_BITS-1:0] h;
    logic [ADDR_BITS-1:0] a;
    pick = $urandom_range(0, 11);
    r = $urandom_range(0, 99);
    act = ($urandom_range(0, 1) == 0) ? ACT_DISPLAY : ACT_RENDER;
    w = pool_w[pick];
    h = pool_h[pick];
    a = pool_a[pick];
    if (r >= 90) begin
      w = WIDTH_BITS'($urandom);
      h = HEIGHT_BITS'($urandom);
      a = ADDR_BITS'($urandom);
    end else if (r >= 78) begin
      case ($urandom_range(0, 2))
        0: w[$urandom_range(0, WIDTH_BITS - 1)] ^= 1'b1;
        1: h[$urandom_range(0, HEIGHT_BITS - 1)] ^= 1'b1;
        default: a[$urandom_range(0, ADDR_BITS - 1)] ^= 1'b1;
      endcase
    end
    send_request(act, w, h, a);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_DISPLAY;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    in_idle_max = 2;
    out_idle_max = 3;
    send_request(ACT_DISPLAY, 11'd1, 11'd1, 24'h000000);
    send_request(ACT_DISPLAY, 11'd1, 11'd1, 24'h000000);
    send_request(ACT_RENDER, 11'd1, 11'd1, 24'h000000);
    send_request(ACT_DISPLAY, 11'd1, 11'd1, 24'h000000);
    send_request(ACT_DISPLAY, 11'd1024, 11'd1024, 24'hFFFFFF);
    send_request(ACT_RENDER, 11'd0, 11'd0, 24'h000000);
    send_request(ACT_DISPLAY, 11'd2047, 11'd2047, 24'hFFFFFF);
    send_request(ACT_RENDER, 11'd1024, 11'd1, 24'h555555);
    send_request(ACT_DISPLAY, 11'd1, 11'd1024, 24'hAAAAAA);
    send_request(ACT_DISPLAY, 11'd1, 11'd1, 24'h000001);
    send_request(ACT_RENDER, 11'h2AA, 11'h555, 24'h123456);
    send_request(ACT_DISPLAY, 11'd640, 11'd480, 24'h200000);
    send_request(ACT_RENDER, 11'd320, 11'd240, 24'h300000);
    send_request(ACT_DISPLAY, 11'd1024, 11'd1024, 24'hFFFFFF);
    send_request(ACT_RENDER, 11'd2047, 11'd2047, 24'hFFFFFF);
    send_request(ACT_DISPLAY, 11'd2047, 11'd2047, 24'hFFFFFF);
    send_request(ACT_RENDER, 11'd0, 11'd0, 24'h000000);
    send_request(ACT_DISPLAY, 11'd640, 11'd480, 24'h200000);
    send_request(ACT_DISPLAY, 11'd1, 11'd1, 24'h000000);
    send_request(ACT_RENDER, 11'd1, 11'd1, 24'h000000);
    hold_until_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle_max = 12; out_idle_max = 12; end
        1: begin in_idle_max = 0; out_idle_max = 0; end
        2: begin in_idle_max = 0; out_idle_max = 12; end
        default: begin in_idle_max = 12; out_idle_max = 0; end
      endcase
      build_key_pool();
      for (int n = 0; n < 285; n++) random_request();
      hold_until_drained();
    end

    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * SLOTS + 4) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
